FILE: rtl/assert_macros.svh
// Assertion helpers, included by rass_select.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/rass_pkg.sv
`default_nettype none
package rass_pkg;

  localparam int MAX_ALIGNS_DEF   = 64;
  localparam int COUNTER_BITS_DEF = 48;

  localparam int RES_CNT_W  = 48;
  localparam int IDX_OUT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd5;

  localparam logic [1:0] GRADE_FULL   = 2'd0;
  localparam logic [1:0] GRADE_GAP    = 2'd1;
  localparam logic [1:0] GRADE_INC    = 2'd2;
  localparam logic [1:0] GRADE_REJECT = 2'd3;

  localparam logic [1:0] LINK_OUTGAP = 2'd0;
  localparam logic [1:0] LINK_INTGAP = 2'd1;
  localparam logic [1:0] LINK_ANCHOR = 2'd2;

  typedef struct packed {
    logic [15:0] threshold;
    logic [19:0] mean;
    logic [19:0] deviation;
  } cfg_t;

  typedef struct packed {
    logic [15:0] read_begin;
    logic [15:0] score;
    logic [1:0]  sg;
    logic [1:0]  eg;
    logic [1:0]  lt;
    logic        rej5;
    logic        rej3;
    logic        nopoint;
    logic        qual;
    logic        last;
  } graded_t;

  function automatic logic [1:0] grade_end(input logic signed [16:0] count,
                                           input logic signed [33:0] p,
                                           input logic [30:0] clen,
                                           input logic [15:0] thr);
    logic signed [34:0] p_w;
    logic signed [34:0] clen_w;
    logic signed [34:0] count_w;
    logic signed [34:0] thr_w;
    logic signed [34:0] off;
    logic signed [34:0] diff;
    logic [1:0]         g;
    p_w     = {p[33], p};
    clen_w  = {4'b0, clen};
    count_w = {{18{count[16]}}, count};
    thr_w   = {19'b0, thr};
    if (p_w < 35'sd1) begin
      off = 35'sd1 - p_w;
    end else if (p_w > clen_w) begin
      off = p_w - clen_w;
    end else begin
      off = '0;
    end
    diff = count_w - off;
    if (count == 17'sd0) begin
      g = GRADE_FULL;
    end else if (off != '0 && diff < thr_w) begin
      g = GRADE_GAP;
    end else if (count_w < thr_w) begin
      g = GRADE_INC;
    end else begin
      g = GRADE_REJECT;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rass_if.sv
`default_nettype none
interface rass_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_begin;
  logic [15:0] read_end;
  logic [15:0] read_length;
  logic [30:0] contig_begin;
  logic [30:0] contig_end;
  logic [30:0] contig_length;
  logic        reverse_strand;
  logic [15:0] align_score;
  logic        last_of_read;

  modport source (
    output valid, read_begin, read_end, read_length, contig_begin, contig_end,
           contig_length, reverse_strand, align_score, last_of_read,
    input  ready
  );
  modport sink (
    input  valid, read_begin, read_end, read_length, contig_begin, contig_end,
           contig_length, reverse_strand, align_score, last_of_read,
    output ready
  );
endinterface

interface rass_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  best_index;
  logic [1:0]  start_grade;
  logic [1:0]  end_grade;
  logic [1:0]  link_type;
  logic [47:0] five_prime_rejects;
  logic [47:0] three_prime_rejects;
  logic [47:0] uninformative_rejects;

  modport source (
    output valid, found, best_index, start_grade, end_grade, link_type,
           five_prime_rejects, three_prime_rejects, uninformative_rejects,
    input  ready
  );
  modport sink (
    input  valid, found, best_index, start_grade, end_grade, link_type,
           five_prime_rejects, three_prime_rejects, uninformative_rejects,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/rass_grade.sv
`default_nettype none
module rass_grade (
  input  logic               clk,
  input  logic               rst_n,
  input  rass_pkg::cfg_t     cfg,
  rass_in_if.sink            in_ch,
  output logic               b_valid,
  output rass_pkg::graded_t  b_item,
  input  logic               b_ready
);

  logic        a_valid_r;
  logic [15:0] a_rb_r;
  logic [15:0] a_re_r;
  logic [15:0] a_rlen_r;
  logic [30:0] a_cb_r;
  logic [30:0] a_ce_r;
  logic [30:0] a_clen_r;
  logic        a_minus_r;
  logic [15:0] a_score_r;
  logic        a_last_r;

  logic              b_valid_r;
  rass_pkg::graded_t b_item_r;
  rass_pkg::graded_t b_item_nxt;

  logic a_free;
  logic b_free;

  logic signed [33:0] pstart;
  logic signed [33:0] pend;
  logic signed [16:0] tail;
  logic signed [33:0] tail_w;
  logic signed [33:0] clen_w;
  logic [22:0]        reach;
  logic signed [33:0] dist_w;
  logic [1:0]         sg;
  logic [1:0]         eg;
  logic               point;
  logic               rej5;
  logic               rej3;

  assign b_free      = !b_valid_r || b_ready;
  assign a_free      = !a_valid_r || b_free;
  assign in_ch.ready = a_free;

  always_comb begin
    tail   = {1'b0, a_rlen_r} - {1'b0, a_re_r};
    tail_w = {{17{tail[16]}}, tail};
    clen_w = {3'b0, a_clen_r};
    if (a_minus_r) begin
      pstart = {3'b0, a_ce_r} + {18'b0, a_rb_r};
      pend   = {3'b0, a_cb_r} + 34'sd1 - tail_w;
    end else begin
      pstart = {3'b0, a_cb_r} + 34'sd1 - {18'b0, a_rb_r};
      pend   = {3'b0, a_ce_r} + tail_w;
    end
    sg     = rass_pkg::grade_end({1'b0, a_rb_r}, pstart, a_clen_r, cfg.threshold);
    eg     = rass_pkg::grade_end(tail, pend, a_clen_r, cfg.threshold);
    reach  = {3'b0, cfg.mean} + {3'b0, cfg.deviation} + {2'b0, cfg.deviation, 1'b0};
    dist_w = {11'b0, reach};
    point  = a_minus_r ? (pstart < dist_w) : (pstart > clen_w - dist_w);
    rej5   = (sg == rass_pkg::GRADE_REJECT);
    rej3   = !rej5 && (eg == rass_pkg::GRADE_REJECT);

    b_item_nxt.read_begin = a_rb_r;
    b_item_nxt.score      = a_score_r;
    b_item_nxt.sg         = sg;
    b_item_nxt.eg         = eg;
    if (sg == rass_pkg::GRADE_GAP) begin
      b_item_nxt.lt = rass_pkg::LINK_OUTGAP;
    end else if (eg == rass_pkg::GRADE_GAP) begin
      b_item_nxt.lt = rass_pkg::LINK_INTGAP;
    end else begin
      b_item_nxt.lt = rass_pkg::LINK_ANCHOR;
    end
    b_item_nxt.rej5    = rej5;
    b_item_nxt.rej3    = rej3;
    b_item_nxt.nopoint = !rej5 && !rej3 && !point;
    b_item_nxt.qual    = !rej5 && !rej3 && point;
    b_item_nxt.last    = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_r <= in_ch.valid;
      end
      if (b_free) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_ch.valid) begin
      a_rb_r    <= in_ch.read_begin;
      a_re_r    <= in_ch.read_end;
      a_rlen_r  <= in_ch.read_length;
      a_cb_r    <= in_ch.contig_begin;
      a_ce_r    <= in_ch.contig_end;
      a_clen_r  <= in_ch.contig_length;
      a_minus_r <= in_ch.reverse_strand;
      a_score_r <= in_ch.align_score;
      a_last_r  <= in_ch.last_of_read;
    end
    if (b_free && a_valid_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign b_valid = b_valid_r;
  assign b_item  = b_item_r;

endmodule
`default_nettype wire

FILE: rtl/rass_select.sv
`default_nettype none
`include "assert_macros.svh"
module rass_select #(
  parameter int MAX_ALIGNS = rass_pkg::MAX_ALIGNS_DEF,
  parameter int CNT_W      = rass_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              b_valid,
  input  rass_pkg::graded_t b_item,
  output logic              b_ready,
  rass_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(MAX_ALIGNS);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(MAX_ALIGNS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  logic             have_best_r;
  logic [15:0]      best_rb_r;
  logic [15:0]      best_score_r;
  logic [IDX_W-1:0] best_pos_r;
  logic [5:0]       best_grades_r;
  logic [IDX_W-1:0] item_cnt_r;
  logic [CNT_W-1:0] cnt5_r;
  logic [CNT_W-1:0] cnt3_r;
  logic [CNT_W-1:0] cntu_r;

  logic             have_best_nxt;
  logic [15:0]      best_rb_nxt;
  logic [15:0]      best_score_nxt;
  logic [IDX_W-1:0] best_pos_nxt;
  logic [5:0]       best_grades_nxt;
  logic [CNT_W-1:0] cnt5_nxt;
  logic [CNT_W-1:0] cnt3_nxt;
  logic [CNT_W-1:0] cntu_nxt;

  logic        out_valid_r;
  logic        out_found_r;
  logic [5:0]  out_idx_r;
  logic [1:0]  out_sg_r;
  logic [1:0]  out_eg_r;
  logic [1:0]  out_lt_r;
  logic [47:0] out_c5_r;
  logic [47:0] out_c3_r;
  logic [47:0] out_cu_r;

  logic [47:0] c5_o;
  logic [47:0] c3_o;
  logic [47:0] cu_o;
  logic [5:0]  pos_o;

  logic       out_free;
  logic       b_go;
  logic       wins;
  logic       take;
  logic       bumpu;
  logic [2:0] bump_vec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign b_ready  = !b_valid || !b_item.last || out_free;
  assign b_go     = b_valid && b_ready;

  always_comb begin
    wins  = !have_best_r || (b_item.read_begin < best_rb_r) ||
            (b_item.read_begin == best_rb_r && b_item.score > best_score_r);
    take  = b_item.qual && wins;
    bumpu = b_item.nopoint || (b_item.qual && have_best_r);
    bump_vec = {b_item.rej5, b_item.rej3, bumpu};

    have_best_nxt   = have_best_r || take;
    best_rb_nxt     = take ? b_item.read_begin : best_rb_r;
    best_score_nxt  = take ? b_item.score : best_score_r;
    best_pos_nxt    = take ? item_cnt_r : best_pos_r;
    best_grades_nxt = take ? {b_item.lt, b_item.eg, b_item.sg} : best_grades_r;

    cnt5_nxt = (b_item.rej5 && cnt5_r != CNT_MAX) ? cnt5_r + CNT_W'(1) : cnt5_r;
    cnt3_nxt = (b_item.rej3 && cnt3_r != CNT_MAX) ? cnt3_r + CNT_W'(1) : cnt3_r;
    cntu_nxt = (bumpu && cntu_r != CNT_MAX) ? cntu_r + CNT_W'(1) : cntu_r;
  end

  generate
    if (CNT_W >= rass_pkg::RES_CNT_W) begin : g_cnt_trunc
      assign c5_o = cnt5_nxt[rass_pkg::RES_CNT_W-1:0];
      assign c3_o = cnt3_nxt[rass_pkg::RES_CNT_W-1:0];
      assign cu_o = cntu_nxt[rass_pkg::RES_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign c5_o = {{(rass_pkg::RES_CNT_W-CNT_W){1'b0}}, cnt5_nxt};
      assign c3_o = {{(rass_pkg::RES_CNT_W-CNT_W){1'b0}}, cnt3_nxt};
      assign cu_o = {{(rass_pkg::RES_CNT_W-CNT_W){1'b0}}, cntu_nxt};
    end
    if (IDX_W >= rass_pkg::IDX_OUT_W) begin : g_pos_trunc
      assign pos_o = best_pos_nxt[rass_pkg::IDX_OUT_W-1:0];
    end else begin : g_pos_ext
      assign pos_o = {{(rass_pkg::IDX_OUT_W-IDX_W){1'b0}}, best_pos_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      item_cnt_r  <= '0;
      cnt5_r      <= '0;
      cnt3_r      <= '0;
      cntu_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_go) begin
        cnt5_r <= cnt5_nxt;
        cnt3_r <= cnt3_nxt;
        cntu_r <= cntu_nxt;
        if (b_item.last) begin
          have_best_r <= 1'b0;
          item_cnt_r  <= '0;
        end else begin
          have_best_r <= have_best_nxt;
          if (item_cnt_r < POS_LAST) begin
            item_cnt_r <= item_cnt_r + IDX_W'(1);
          end
        end
      end
      if (b_go && b_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && !b_item.last) begin
      best_rb_r     <= best_rb_nxt;
      best_score_r  <= best_score_nxt;
      best_pos_r    <= best_pos_nxt;
      best_grades_r <= best_grades_nxt;
    end
    if (b_go && b_item.last) begin
      out_found_r <= have_best_nxt;
      out_idx_r   <= have_best_nxt ? pos_o : '0;
      out_sg_r    <= have_best_nxt ? best_grades_nxt[1:0] : rass_pkg::GRADE_FULL;
      out_eg_r    <= have_best_nxt ? best_grades_nxt[3:2] : rass_pkg::GRADE_FULL;
      out_lt_r    <= have_best_nxt ? best_grades_nxt[5:4] : rass_pkg::LINK_OUTGAP;
      out_c5_r    <= c5_o;
      out_c3_r    <= c3_o;
      out_cu_r    <= cu_o;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.found                 = out_found_r;
  assign out_ch.best_index            = out_idx_r;
  assign out_ch.start_grade           = out_sg_r;
  assign out_ch.end_grade             = out_eg_r;
  assign out_ch.link_type             = out_lt_r;
  assign out_ch.five_prime_rejects    = out_c5_r;
  assign out_ch.three_prime_rejects   = out_c3_r;
  assign out_ch.uninformative_rejects = out_cu_r;

  `ASSERT_NEXT(a_res_after_last, clk, rst_n, b_go && b_item.last, out_valid_r, "no result after last item")
  `ASSERT_NEXT(a_pos_clear, clk, rst_n, b_go && b_item.last, item_cnt_r == '0, "position not cleared")
  `ASSERT_CLK(a_one_bump, clk, rst_n, b_go |-> $countones(bump_vec) <= 1, "two counters bumped")
  `ASSERT_CLK(a_cnt_mono, clk, rst_n, $past(rst_n) |-> cntu_r >= $past(cntu_r), "counter went down")
  `ASSERT_CLK(a_empty_res, clk, rst_n, (out_valid_r && !out_found_r) |-> (out_idx_r == '0 && out_lt_r == rass_pkg::LINK_OUTGAP), "empty result not zeroed")

endmodule
`default_nettype wire

FILE: rtl/read_alignment_span_selector_top.sv
// The result of a last_of_read item passes grade stages A and B, then the result register.
// Throughput: one item per cycle while not stalled; running best and counters update per item.
// A held result stalls only the next last_of_read item; other items keep flowing
// until the two pipeline registers fill.
// Reset: synchronous, active low; clears pipeline valids, running best, item position,
// reject counters, and sets unaligned_threshold to 5, insert mean and deviation to 0.
`default_nettype none
module read_alignment_span_selector_top #(
  parameter int MAX_ALIGNS_PER_READ = rass_pkg::MAX_ALIGNS_DEF,
  parameter int COUNTER_BITS        = rass_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rass_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rass_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rass_in_if.sink                         in_ch,
  rass_out_if.source                      out_ch
);

  rass_pkg::cfg_t    cfg_r;
  logic              b_valid;
  logic              b_ready;
  rass_pkg::graded_t b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= rass_pkg::THRESHOLD_RST;
      cfg_r.mean      <= '0;
      cfg_r.deviation <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rass_pkg::REG_THRESHOLD: cfg_r.threshold <= cfg_wdata[15:0];
        rass_pkg::REG_MEAN:      cfg_r.mean      <= cfg_wdata;
        rass_pkg::REG_DEVIATION: cfg_r.deviation <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rass_grade u_grade (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .b_valid (b_valid),
    .b_item  (b_item),
    .b_ready (b_ready)
  );

  rass_select #(
    .MAX_ALIGNS (MAX_ALIGNS_PER_READ),
    .CNT_W      (COUNTER_BITS)
  ) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_valid (b_valid),
    .b_item  (b_item),
    .b_ready (b_ready),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: dv/read_alignment_span_selector_top_tb.sv
`timescale 1ns / 1ps
module read_alignment_span_selector_top_tb;

  localparam int REJ_FIVE = 0;
  localparam int REJ_THREE = 1;
  localparam int REJ_UNINF = 2;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [15:0] rb;
    logic [15:0] re;
    logic [15:0] rlen;
    logic [30:0] cb;
    logic [30:0] ce;
    logic [30:0] clen;
    logic        minus;
    logic [15:0] score;
    logic        last;
  } align_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  idx;
    logic [1:0]  sg;
    logic [1:0]  eg;
    logic [1:0]  lt;
    logic [47:0] r5;
    logic [47:0] r3;
    logic [47:0] ru;
  } span_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rass_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rass_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rass_in_if in_ch ();
  rass_out_if out_ch ();

  read_alignment_span_selector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers and running selection
  logic [15:0] thr_cfg = rass_pkg::THRESHOLD_RST;
  logic [19:0] mean_cfg = '0;
  logic [19:0] dev_cfg = '0;
  logic        run_have = 1'b0;
  logic [15:0] run_begin = '0;
  logic [15:0] run_score = '0;
  logic [5:0]  run_pos = '0;
  logic [1:0]  run_sg = rass_pkg::GRADE_FULL;
  logic [1:0]  run_eg = rass_pkg::GRADE_FULL;
  logic [1:0]  run_lt = rass_pkg::LINK_OUTGAP;
  logic [5:0]  item_pos = '0;
  logic [47:0] reject_tally [3] = '{48'd0, 48'd0, 48'd0};

  align_t align_queue[$];
  span_t  span_expect[$];
  int     mismatches = 0;

  align_t      feed_item;
  align_t      seen_item;
  span_t       seen_span;
  span_t       want_span;
  logic [2:0]  feed_gap;
  logic        feed_eager = 1'b0;
  logic [2:0]  sink_wait;
  logic        sink_eager = 1'b0;
  int unsigned sink_pause;
  int unsigned sink_count;
  int unsigned hold_left;
  int unsigned idle_cycles;

  function automatic logic [1:0] rate_end(input longint count, input longint p,
                                          input longint clen);
    longint off;
    longint limit;
    limit = thr_cfg;
    if (p < 1) off = 1 - p;
    else if (p > clen) off = p - clen;
    else off = 0;
    if (count == 0) return rass_pkg::GRADE_FULL;
    if (off > 0 && count - off < limit) return rass_pkg::GRADE_GAP;
    if (count < limit) return rass_pkg::GRADE_INC;
    return rass_pkg::GRADE_REJECT;
  endfunction

  function automatic void count_reject(input int which);
    if (reject_tally[which] != {48{1'b1}}) reject_tally[which] = reject_tally[which] + 1;
  endfunction

  function automatic void select_span(input align_t a);
    longint rb, rlen, re, cb, ce, clen, ps, pe, tail, reach;
    logic [1:0] sg, eg;
    logic [5:0] pos;
    logic pointing;
    span_t res;
    pos = item_pos;
    if (item_pos < rass_pkg::MAX_ALIGNS_DEF - 1) item_pos = item_pos + 1;
    rb = a.rb;
    re = a.re;
    rlen = a.rlen;
    cb = a.cb;
    ce = a.ce;
    clen = a.clen;
    ps = a.minus ? ce + rb : cb + 1 - rb;
    sg = rate_end(rb, ps, clen);
    if (sg == rass_pkg::GRADE_REJECT) begin
      count_reject(REJ_FIVE);
    end else begin
      tail = rlen - re;
      pe = a.minus ? cb + 1 - tail : ce + tail;
      eg = rate_end(tail, pe, clen);
      if (eg == rass_pkg::GRADE_REJECT) begin
        count_reject(REJ_THREE);
      end else begin
        reach = longint'(mean_cfg) + 3 * longint'(dev_cfg);
        pointing = a.minus ? (ps < reach) : (ps > clen - reach);
        if (!pointing) begin
          count_reject(REJ_UNINF);
        end else if (!run_have || a.rb < run_begin ||
                     (a.rb == run_begin && a.score > run_score)) begin
          if (run_have) count_reject(REJ_UNINF);
          run_have = 1'b1;
          run_begin = a.rb;
          run_score = a.score;
          run_pos = pos;
          run_sg = sg;
          run_eg = eg;
          run_lt = (sg == rass_pkg::GRADE_GAP) ? rass_pkg::LINK_OUTGAP :
                   (eg == rass_pkg::GRADE_GAP) ? rass_pkg::LINK_INTGAP :
                   rass_pkg::LINK_ANCHOR;
        end else begin
          count_reject(REJ_UNINF);
        end
      end
    end
    if (a.last) begin
      res.found = run_have;
      res.idx = run_have ? run_pos : '0;
      res.sg = run_have ? run_sg : rass_pkg::GRADE_FULL;
      res.eg = run_have ? run_eg : rass_pkg::GRADE_FULL;
      res.lt = run_have ? run_lt : rass_pkg::LINK_OUTGAP;
      res.r5 = reject_tally[REJ_FIVE];
      res.r3 = reject_tally[REJ_THREE];
      res.ru = reject_tally[REJ_UNINF];
      span_expect = {span_expect, res};
      run_have = 1'b0;
      run_begin = '0;
      run_score = '0;
      run_pos = '0;
      run_sg = rass_pkg::GRADE_FULL;
      run_eg = rass_pkg::GRADE_FULL;
      run_lt = rass_pkg::LINK_OUTGAP;
      item_pos = '0;
    end
  endfunction

  function automatic logic [30:0] fit31(input longint v);
    if (v < 0) return '0;
    if (v > 64'h7fff_ffff) return '1;
    return v[30:0];
  endfunction

  function automatic align_t make_align(input bit last);
    align_t a;
    longint reach, clen, rlen, rb, re, span, ps, cb, ce;
    a = '0;
    a.last = last;
    if ($urandom_range(0, 9) == 0) begin
      a.rb = 16'($urandom);
      a.re = 16'($urandom);
      a.rlen = 16'($urandom);
      a.cb = 31'($urandom);
      a.ce = 31'($urandom);
      a.clen = 31'($urandom);
      a.minus = 1'($urandom);
      a.score = 16'($urandom);
      return a;
    end
    reach = longint'(mean_cfg) + 3 * longint'(dev_cfg);
    a.minus = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: clen = $urandom_range(0, 3);
      1: clen = 64'h7fff_ffff;
      default: clen = $urandom_range(200, 100000);
    endcase
    rlen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(30, 300);
    rb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rlen) : $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: re = rlen + $urandom_range(1, 40);
      1: re = $urandom_range(0, rlen);
      default: re = rlen - $urandom_range(0, 6);
    endcase
    if (re < 0) re = 0;
    if (re > 65535) re = 65535;
    span = (re > rb) ? re - rb : 0;
    if ($urandom_range(0, 3) == 0) begin
      cb = $urandom_range(0, clen);
      ce = cb + span;
    end else if (a.minus) begin
      ps = longint'($urandom_range(0, reach + 8)) - 4;
      ce = ps - rb;
      cb = ce - span;
    end else begin
      ps = clen - reach - 4 + longint'($urandom_range(0, reach + 8));
      cb = ps - 1 + rb;
      ce = cb + span;
    end
    a.rb = rb[15:0];
    a.re = re[15:0];
    a.rlen = rlen[15:0];
    a.cb = fit31(cb);
    a.ce = fit31(ce);
    a.clen = fit31(clen);
    a.score = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    return a;
  endfunction

  task automatic add_align(input logic [15:0] rb, input logic [15:0] re,
                           input logic [15:0] rlen, input logic [30:0] cb,
                           input logic [30:0] ce, input logic [30:0] clen,
                           input logic minus, input logic [15:0] score, input logic last);
    align_t a;
    a = '{rb, re, rlen, cb, ce, clen, minus, score, last};
    align_queue = {align_queue, a};
  endtask

  task automatic queue_reads(input int n_items);
    int left, len, i, pick;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) len = $urandom_range(64, 70);
      else if (pick < 40) len = 1;
      else len = $urandom_range(2, 6);
      for (i = 0; i < len; i++) align_queue = {align_queue, make_align(i == len - 1)};
      left -= len;
    end
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [19:0] mean,
                            input logic [19:0] dev);
    thr_cfg = thr;
    mean_cfg = mean;
    dev_cfg = dev;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= rass_pkg::REG_THRESHOLD;
    cfg_wdata <= {4'b0, thr};
    @(posedge clk);
    cfg_index <= rass_pkg::REG_MEAN;
    cfg_wdata <= mean;
    @(posedge clk);
    cfg_index <= rass_pkg::REG_DEVIATION;
    cfg_wdata <= dev;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // all items transferred, all results back, then latency slack for resultless items
  task automatic drain();
    do @(negedge clk);
    while (align_queue.size() != 0 || in_ch.valid || span_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic report_error(input string msg);
    if (mismatches < 100) $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      feed_gap <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (feed_gap != 0) begin
        feed_gap <= feed_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (align_queue.size() != 0) begin
        feed_item = align_queue.pop_front();
        in_ch.read_begin <= feed_item.rb;
        in_ch.read_end <= feed_item.re;
        in_ch.read_length <= feed_item.rlen;
        in_ch.contig_begin <= feed_item.cb;
        in_ch.contig_end <= feed_item.ce;
        in_ch.contig_length <= feed_item.clen;
        in_ch.reverse_strand <= feed_item.minus;
        in_ch.align_score <= feed_item.score;
        in_ch.last_of_read <= feed_item.last;
        in_ch.valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) feed_eager <= !feed_eager;
        feed_gap <= feed_eager ? 3'd0 : 3'($urandom_range(0, 7));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: per-result stall, plus long hold-offs that back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait <= '0;
      sink_count <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (out_ch.valid && out_ch.ready) begin
      sink_count <= sink_count + 1;
      if (sink_count == 30 || sink_count == 110) begin
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) sink_eager <= !sink_eager;
        sink_pause = sink_eager ? 0 : $urandom_range(0, 7);
        sink_wait <= 3'(sink_pause);
        out_ch.ready <= (sink_pause == 0);
      end
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ch.ready <= (sink_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_item.rb = in_ch.read_begin;
        seen_item.re = in_ch.read_end;
        seen_item.rlen = in_ch.read_length;
        seen_item.cb = in_ch.contig_begin;
        seen_item.ce = in_ch.contig_end;
        seen_item.clen = in_ch.contig_length;
        seen_item.minus = in_ch.reverse_strand;
        seen_item.score = in_ch.align_score;
        seen_item.last = in_ch.last_of_read;
        select_span(seen_item);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_span.found = out_ch.found;
        seen_span.idx = out_ch.best_index;
        seen_span.sg = out_ch.start_grade;
        seen_span.eg = out_ch.end_grade;
        seen_span.lt = out_ch.link_type;
        seen_span.r5 = out_ch.five_prime_rejects;
        seen_span.r3 = out_ch.three_prime_rejects;
        seen_span.ru = out_ch.uninformative_rejects;
        if (span_expect.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          want_span = span_expect.pop_front();
          check_field("found", seen_span.found, want_span.found);
          check_field("best_index", seen_span.idx, want_span.idx);
          check_field("start_grade", seen_span.sg, want_span.sg);
          check_field("end_grade", seen_span.eg, want_span.eg);
          check_field("link_type", seen_span.lt, want_span.lt);
          check_field("five_prime_rejects", seen_span.r5, want_span.r5);
          check_field("three_prime_rejects", seen_span.r3, want_span.r3);
          check_field("uninformative_rejects", seen_span.ru, want_span.ru);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rass_pkg::REG_THRESHOLD;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.read_begin = '0;
    in_ch.read_end = '0;
    in_ch.read_length = '0;
    in_ch.contig_begin = '0;
    in_ch.contig_end = '0;
    in_ch.contig_length = '0;
    in_ch.reverse_strand = 1'b0;
    in_ch.align_score = '0;
    in_ch.last_of_read = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: all-zero, all-ones, negative tail, outranking and ties, rejects
    add_align(16'd0, 16'd0, 16'd0, 31'd0, 31'd0, 31'd0, 1'b0, 16'd0, 1'b1);
    add_align('1, '1, '1, '1, '1, '1, 1'b1, '1, 1'b1);
    add_align(16'd0, 16'd120, 16'd100, 31'd1000, 31'd1100, 31'd1000, 1'b0, 16'd7, 1'b1);
    add_align(16'd3, 16'd100, 16'd100, 31'd503, 31'd600, 31'd500, 1'b0, 16'd10, 1'b0);
    add_align(16'd1, 16'd100, 16'd100, 31'd501, 31'd600, 31'd500, 1'b0, 16'd5, 1'b0);
    add_align(16'd1, 16'd100, 16'd100, 31'd501, 31'd600, 31'd500, 1'b0, 16'd5, 1'b0);
    add_align(16'd1, 16'd100, 16'd100, 31'd501, 31'd600, 31'd500, 1'b0, 16'd9, 1'b1);
    add_align(16'd10, 16'd100, 16'd100, 31'd100, 31'd190, 31'd1000, 1'b0, 16'd1, 1'b1);
    add_align(16'd0, 16'd50, 16'd100, 31'd10, 31'd60, 31'd1000, 1'b0, 16'd2, 1'b0);
    add_align(16'd0, 16'd100, 16'd100, 31'd1000, 31'd1100, 31'd1000, 1'b0, 16'd3, 1'b1);
    drain();

    // minus strand can only point out with a nonzero insert window
    set_config(16'd5, 20'd100, 20'd10);
    add_align(16'd2, 16'd99, 16'd100, 31'd0, 31'd50, 31'd1000, 1'b1, 16'd4, 1'b0);
    add_align(16'd0, 16'd100, 16'd100, 31'd10, 31'd100, 31'd1000, 1'b0, 16'd8, 1'b1);
    add_align(16'd4, 16'd96, 16'd100, 31'd0, 31'd120, 31'd1000, 1'b1, 16'd0, 1'b0);
    add_align(16'd4, 16'd100, 16'd100, 31'd30, 31'd122, 31'd1000, 1'b1, '1, 1'b1);
    drain();
    queue_reads(120);
    drain();

    set_config(16'd0, 20'd0, 20'd0);
    queue_reads(80);
    drain();

    // every item qualifies with a smaller read_begin; winner position saturates
    set_config('1, '1, '1);
    for (i = 0; i < 70; i++)
      add_align(16'(69 - i), 16'd200, 16'd200, 31'd500, 31'd600, 31'd1000, 1'b0, 16'(i),
                i == 69);
    queue_reads(60);
    drain();

    repeat (3) begin
      set_config(16'($urandom_range(1, 40)), 20'($urandom_range(0, 3000)),
                 20'($urandom_range(0, 1000)));
      queue_reads(80);
      drain();
    end

    set_config(16'd12, '1, 20'd0);
    queue_reads(60);
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: read_alignment_span_selector_top.f
+incdir+rtl
rtl/rass_pkg.sv
rtl/rass_if.sv
rtl/rass_grade.sv
rtl/rass_select.sv
rtl/read_alignment_span_selector_top.sv
dv/read_alignment_span_selector_top_tb.sv
